@@ rtl/nv21ra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21ra_pkg
// Shared types, register indexes and reset values of the NV21 rotation
// address generator.
// ----------------------------------------------------------------------------
package nv21ra_pkg;

  localparam int ADDR_W   = 25;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_STRIDE = 8192;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_CODE = 3'd4;

  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [STRIDE_W-1:0] RST_LUMA_STRIDE   = 14'd640;
  localparam logic [STRIDE_W-1:0] RST_CHROMA_STRIDE = 14'd640;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [STRIDE_W-1:0] luma_stride;
    logic [STRIDE_W-1:0] chroma_stride;
    rot_t                rotation_code;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] luma_read_addr;
    logic [ADDR_W-1:0] chroma_read_addr;
    logic [ADDR_W-1:0] luma_write_addr;
    logic [ADDR_W-1:0] chroma_write_addr;
    logic              inside_frame;
    logic              last_pixel;
  } result_t;

endpackage

@@ rtl/nv21ra_addr_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21ra_addr_calc
// Combinational address math for one source coordinate: clamp the frame
// registers, map the coordinate through the rotation, form read and write
// byte offsets.
// ----------------------------------------------------------------------------
module nv21ra_addr_calc
  import nv21ra_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] pixel_column,
  input  logic [COORD_W-1:0] pixel_row,
  output result_t            res
);

  localparam logic [DIM_W:0]    MaxW = (DIM_W + 1)'(MAX_WIDTH);
  localparam logic [DIM_W:0]    MaxH = (DIM_W + 1)'(MAX_HEIGHT);
  localparam logic [STRIDE_W:0] MaxS = (STRIDE_W + 1)'(MAX_STRIDE);

  logic [DIM_W:0]    w_sat, h_sat;
  logic [STRIDE_W:0] ys_sat, cs_sat;
  logic [DIM_W-1:0]  w, h, wm1, hm1, i13, j13;
  logic [STRIDE_W-1:0] ys, cs;
  logic in_frame;
  logic [2*DIM_W-1:0] y_prod, c_prod, yw_prod, cw_prod;
  logic [ADDR_W-1:0]  yr, cr, yw_rot, cw_rot;
  logic [DIM_W-1:0]   io, jo, wo;

  // Clamp registers to the supported maxima; the result never exceeds the
  // register value, so the narrow part-select keeps it.
  assign w_sat  = ({1'b0, cfg.frame_width}   > MaxW) ? MaxW : {1'b0, cfg.frame_width};
  assign h_sat  = ({1'b0, cfg.frame_height}  > MaxH) ? MaxH : {1'b0, cfg.frame_height};
  assign ys_sat = ({1'b0, cfg.luma_stride}   > MaxS) ? MaxS : {1'b0, cfg.luma_stride};
  assign cs_sat = ({1'b0, cfg.chroma_stride} > MaxS) ? MaxS : {1'b0, cfg.chroma_stride};
  assign w  = w_sat[DIM_W-1:0];
  assign h  = h_sat[DIM_W-1:0];
  assign ys = ys_sat[STRIDE_W-1:0];
  assign cs = cs_sat[STRIDE_W-1:0];

  assign i13 = {1'b0, pixel_column};
  assign j13 = {1'b0, pixel_row};
  assign wm1 = w - 13'd1;
  assign hm1 = h - 13'd1;
  assign in_frame = (i13 < w) && (j13 < h);

  // Source layout
  assign y_prod = (2*DIM_W)'(pixel_row) * (2*DIM_W)'(ys);
  assign c_prod = (2*DIM_W)'(pixel_row[COORD_W-1:1]) * (2*DIM_W)'(cs);
  assign yr = y_prod[ADDR_W-1:0] + ADDR_W'(pixel_column);
  assign cr = c_prod[ADDR_W-1:0] + ADDR_W'({pixel_column[COORD_W-1:1], 1'b0});

  // Rotated coordinate and packed output pitch
  always_comb begin
    case (cfg.rotation_code)
      ROT_90: begin
        wo = h;
        io = hm1 - j13;
        jo = i13;
      end
      ROT_180: begin
        wo = w;
        io = wm1 - i13;
        jo = hm1 - j13;
      end
      ROT_270: begin
        wo = h;
        io = j13;
        jo = wm1 - i13;
      end
      default: begin
        wo = '0;
        io = '0;
        jo = '0;
      end
    endcase
  end

  assign yw_prod = (2*DIM_W)'(jo) * (2*DIM_W)'(wo);
  assign cw_prod = (2*DIM_W)'(jo[DIM_W-1:1]) * (2*DIM_W)'(wo);
  assign yw_rot = yw_prod[ADDR_W-1:0] + ADDR_W'(io);
  assign cw_rot = cw_prod[ADDR_W-1:0] + ADDR_W'({io[DIM_W-1:1], 1'b0});

  always_comb begin
    res = '0;
    if (in_frame) begin
      res.luma_read_addr   = yr;
      res.chroma_read_addr = cr;
      res.luma_write_addr   = (cfg.rotation_code == ROT_0) ? yr : yw_rot;
      res.chroma_write_addr = (cfg.rotation_code == ROT_0) ? cr : cw_rot;
      res.inside_frame = 1'b1;
      res.last_pixel   = (i13 == wm1) && (j13 == hm1);
    end
  end

endmodule

@@ rtl/nv21_rotation_address_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21_rotation_address_generator
// Per-pixel read and rotated write byte offsets for the luma and interleaved
// chroma planes of an NV21 frame.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Transaction
//  -------  ---------  ------------------  ---------------------------------
//  in_      in         in_valid/in_stall   source column and row
//  out_     out        out_valid/out_stall four offsets, inside and last flags
//  cfg_     in         cfg_valid/cfg_ready register index and write data
//
//  One transaction per cycle sustained while out_stall is low; the edge
//  that takes an input loads the input register, and its result shows on
//  the port once the result register loads it, which out_stall can delay.
//  The four multipliers (12x14, 11x14, 13x13 and 12x13 bits) and their
//  adders sit between the two registers; that path sets the clock.
//  cfg_ready is always high; write registers only while the block is idle.
//  Synchronous reset clears the valid bits and loads register defaults.
//  out_stall holds a full result register and, once the input register
//  is also full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module nv21_rotation_address_generator
  import nv21ra_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_W-1:0]    in_pixel_column,
  input  logic [COORD_W-1:0]    in_pixel_row,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_W-1:0]     out_luma_read_addr,
  output logic [ADDR_W-1:0]     out_chroma_read_addr,
  output logic [ADDR_W-1:0]     out_luma_write_addr,
  output logic [ADDR_W-1:0]     out_chroma_write_addr,
  output logic                  out_inside_frame,
  output logic                  out_last_pixel,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0] col_r, row_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  result_t res_calc;
  logic    advance, in_take;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= RST_FRAME_WIDTH;
      cfg_r.frame_height  <= RST_FRAME_HEIGHT;
      cfg_r.luma_stride   <= RST_LUMA_STRIDE;
      cfg_r.chroma_stride <= RST_CHROMA_STRIDE;
      cfg_r.rotation_code <= ROT_0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_wdata[DIM_W-1:0];
        CFG_LUMA_STRIDE:   cfg_r.luma_stride   <= cfg_wdata[STRIDE_W-1:0];
        CFG_CHROMA_STRIDE: cfg_r.chroma_stride <= cfg_wdata[STRIDE_W-1:0];
        CFG_ROTATION_CODE: cfg_r.rotation_code <= rot_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline control: the result register advances when empty or taken;
  // the input register refills whenever it is not held behind a stall.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the coordinate of an accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      col_r <= in_pixel_column;
      row_r <= in_pixel_row;
    end
  end

  nv21ra_addr_calc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_STRIDE (MAX_STRIDE)
  ) u_calc (
    .cfg          (cfg_r),
    .pixel_column (col_r),
    .pixel_row    (row_r),
    .res          (res_calc)
  );

  // Load the result register only with a live item; hold it under stall
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_calc;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_luma_read_addr    = res_r.luma_read_addr;
  assign out_chroma_read_addr  = res_r.chroma_read_addr;
  assign out_luma_write_addr   = res_r.luma_write_addr;
  assign out_chroma_write_addr = res_r.chroma_write_addr;
  assign out_inside_frame      = res_r.inside_frame;
  assign out_last_pixel        = res_r.last_pixel;

endmodule

@@ rtl/nv21ra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21ra_checker
// Port-level checks of the NV21 rotation address generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module nv21ra_checker
  import nv21ra_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ADDR_W-1:0] out_luma_read_addr,
  input logic [ADDR_W-1:0] out_chroma_read_addr,
  input logic [ADDR_W-1:0] out_luma_write_addr,
  input logic [ADDR_W-1:0] out_chroma_write_addr,
  input logic              out_inside_frame,
  input logic              out_last_pixel
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_luma_read_addr)
      && $stable(out_luma_write_addr) && $stable(out_inside_frame))
    else $error("stalled result changed");

  // The input side only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Outside coordinates give an all-zero result
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_frame |-> out_luma_read_addr == '0
      && out_chroma_read_addr == '0 && out_luma_write_addr == '0
      && out_chroma_write_addr == '0 && !out_last_pixel)
    else $error("outside coordinate gave a nonzero result");

  // The last pixel lies inside the frame
  a_last_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_inside_frame)
    else $error("last pixel flagged outside the frame");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nv21_rotation_address_generator nv21ra_checker u_nv21ra_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_luma_read_addr    (out_luma_read_addr),
  .out_chroma_read_addr  (out_chroma_read_addr),
  .out_luma_write_addr   (out_luma_write_addr),
  .out_chroma_write_addr (out_chroma_write_addr),
  .out_inside_frame      (out_inside_frame),
  .out_last_pixel        (out_last_pixel)
);
